FILE: rtl/scae_pkg.sv
// shared types and constants for the sparse constraint apply engine
`default_nettype none
package scae_pkg;

	localparam int VECTOR_DEPTH = 4096;
	localparam int MAX_BLOCK    = 64;
	localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
	localparam int BS_W         = 7;
	localparam int ID_W         = 12;
	localparam int COMP_W       = 6;
	localparam int LIN_W        = ID_W + BS_W;
	localparam int DATA_W       = 48;
	localparam int HALF_W       = DATA_W / 2;
	localparam int PACC_W       = 2 * DATA_W;
	localparam int FRAC_W       = 32;

	localparam logic [BS_W-1:0]   MAX_BLOCK_BS = BS_W'(MAX_BLOCK);
	localparam logic [DATA_W-1:0] QMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] QMIN = {1'b1, {(DATA_W-1){1'b0}}};

	// request function codes
	localparam logic [2:0] F_WRITE   = 3'd0;
	localparam logic [2:0] F_READ    = 3'd1;
	localparam logic [2:0] F_START   = 3'd2;
	localparam logic [2:0] F_GATHER  = 3'd3;
	localparam logic [2:0] F_SCATTER = 3'd4;
	localparam logic [2:0] F_ZERO    = 3'd5;
	localparam logic [2:0] F_SCALE   = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDR,
		S_WR,
		S_RD_OP,
		S_RD_ACC,
		S_MUL,
		S_RND,
		S_ADD,
		S_CLR,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/sparse_constraint_apply_engine.sv
// Sparse constraint apply engine: one request at a time against a 4096 x 48 bit
// vector store held in a single synchronous memory. A request is taken only
// while the sequencer is idle; the result sits in an output register, so the
// next request can be taken while an earlier result waits. The sequencer walks
// one memory read port and a 24 x 24 bit multiplier that builds the 48 x 48 bit
// product from four partial products. Out of range or unused codes go straight
// to the result; write/start/zero write an entry, read reads one, scale reads,
// multiplies and rounds, gather/scatter then add and write back (the last
// scatter term of a row also clears the row entry). Values are signed Q16.32;
// products round half away from zero; products and sums saturate (status 2).
`default_nettype none
module sparse_constraint_apply_engine
	import scae_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [BS_W-1:0]          cfg_wr_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               func,
	input  wire logic [ID_W-1:0]          row_id,
	input  wire logic [ID_W-1:0]          column_id,
	input  wire logic [COMP_W-1:0]        component,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic signed [DATA_W-1:0] coefficient,
	input  wire logic                     last_in_row,
	input  wire logic                     last_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [1:0]                    status,
	output logic                          pass_done
);

	state_t state_q, state_d;

	logic [BS_W-1:0]   blk_size_q;
	logic [1:0]        cnt_q;

	// request registers
	logic [2:0]        func_q;
	logic [ID_W-1:0]   row_q, col_q;
	logic [COMP_W-1:0] comp_q;
	logic [DATA_W-1:0] value_q, coef_q;
	logic              last_row_q, last_item_q;

	// working registers
	logic [ADDR_W-1:0] ra_q, ca_q;
	logic              rok_q, cok_q;
	logic [DATA_W-1:0] cmag_q, omag_q, acc_q, prod_q, rv_q;
	logic              csign_q, osign_q, sat_q, bad_q;
	logic [PACC_W-1:0] pacc_q;
	logic [DATA_W-1:0] rd_data_q;

	logic              out_valid_q, pass_done_q;
	logic [DATA_W-1:0] read_value_q;
	logic [1:0]        status_q;

	logic [DATA_W-1:0] mem [VECTOR_DEPTH];

	// address generation
	logic [BS_W-1:0]   bs_eff;
	logic [LIN_W-1:0]  row_lin, col_lin;
	logic              comp_ok, rok, cok, bad;

	// datapath
	logic [ADDR_W-1:0] op_addr, acc_addr, rd_addr, wr_addr;
	logic              mem_we;
	logic [DATA_W-1:0] wr_data;
	logic [HALF_W-1:0] a_part, b_part;
	logic [DATA_W-1:0] pp;
	logic [PACC_W-1:0] pp_sh;
	logic [PACC_W-1:0] rsum;
	logic [DATA_W+15:0] rmag;
	logic              neg, prod_sat;
	logic [DATA_W-1:0] prod;
	logic [DATA_W:0]   sum;
	logic              sum_sat;
	logic [DATA_W-1:0] sum_c;
	logic              out_load;

	assign bs_eff  = (blk_size_q > MAX_BLOCK_BS) ? MAX_BLOCK_BS : blk_size_q;
	assign comp_ok = BS_W'(comp_q) < bs_eff;
	assign row_lin = LIN_W'(row_q) * LIN_W'(bs_eff) + LIN_W'(comp_q);
	assign col_lin = LIN_W'(col_q) * LIN_W'(bs_eff) + LIN_W'(comp_q);
	assign rok     = comp_ok && (row_lin < LIN_W'(VECTOR_DEPTH));
	assign cok     = comp_ok && (col_lin < LIN_W'(VECTOR_DEPTH));

	always_comb begin
		case (func_q) inside
			F_WRITE, F_READ, F_START, F_ZERO: bad = !rok;
			F_GATHER, F_SCATTER:              bad = !(rok && cok);
			F_SCALE:                          bad = !cok;
			default:                          bad = 1'b0;
		endcase
	end

	// scatter multiplies the row entry into the column, the others the reverse
	assign op_addr  = (func_q == F_SCATTER || func_q == F_READ) ? ra_q : ca_q;
	assign acc_addr = (func_q == F_SCATTER) ? ca_q : ra_q;

	// one 24 x 24 partial product per cycle
	assign a_part = cnt_q[0] ? cmag_q[DATA_W-1:HALF_W] : cmag_q[HALF_W-1:0];
	assign b_part = cnt_q[1] ? omag_q[DATA_W-1:HALF_W] : omag_q[HALF_W-1:0];
	assign pp     = DATA_W'(a_part) * DATA_W'(b_part);

	always_comb begin
		case ({cnt_q[1], cnt_q[0]})
			2'b00:   pp_sh = PACC_W'(pp);
			2'b11:   pp_sh = {pp, {DATA_W{1'b0}}};
			default: pp_sh = PACC_W'({pp, {HALF_W{1'b0}}});
		endcase
	end

	// round half away from zero on the magnitude, then saturate
	assign rsum     = pacc_q + (PACC_W'(1) << (FRAC_W - 1));
	assign rmag     = rsum[PACC_W-1:FRAC_W];
	assign neg      = csign_q ^ osign_q;
	assign prod_sat = neg ? (rmag > (DATA_W+16)'(QMIN)) : (rmag > (DATA_W+16)'(QMAX));
	always_comb begin
		if (prod_sat) begin
			prod = neg ? QMIN : QMAX;
		end else if (neg) begin
			prod = DATA_W'(0) - rmag[DATA_W-1:0];
		end else begin
			prod = rmag[DATA_W-1:0];
		end
	end

	assign sum     = {acc_q[DATA_W-1], acc_q} + {prod_q[DATA_W-1], prod_q};
	assign sum_sat = sum[DATA_W] != sum[DATA_W-1];
	assign sum_c   = sum_sat ? (sum[DATA_W] ? QMIN : QMAX) : sum[DATA_W-1:0];

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		rd_addr = acc_addr;
		mem_we  = 1'b0;
		wr_addr = ra_q;
		wr_data = value_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				if (bad) begin
					state_d = S_OUT;
				end else begin
					case (func_q) inside
						F_WRITE, F_START, F_ZERO:             state_d = S_WR;
						F_READ, F_GATHER, F_SCATTER, F_SCALE: state_d = S_RD_OP;
						default:                              state_d = S_OUT;
					endcase
				end
			end
			S_WR: begin
				mem_we  = 1'b1;
				wr_data = (func_q == F_ZERO) ? '0 : value_q;
				state_d = S_OUT;
			end
			S_RD_OP: begin
				rd_addr = op_addr;
				state_d = S_RD_ACC;
			end
			S_RD_ACC: begin
				state_d = (func_q == F_READ) ? S_OUT : S_MUL;
			end
			S_MUL: begin
				if (cnt_q == 2'd3) begin
					state_d = S_RND;
				end
			end
			S_RND: begin
				state_d = (func_q == F_SCALE) ? S_OUT : S_ADD;
			end
			S_ADD: begin
				mem_we  = 1'b1;
				wr_addr = acc_addr;
				wr_data = sum_c;
				state_d = (func_q == F_SCATTER && last_row_q) ? S_CLR : S_OUT;
			end
			S_CLR: begin
				mem_we  = 1'b1;
				wr_addr = ra_q;
				wr_data = '0;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			blk_size_q  <= BS_W'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				blk_size_q <= cfg_wr_data;
			end
			cnt_q <= (state_q == S_MUL) ? cnt_q + 2'd1 : 2'd0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q      <= func;
			row_q       <= row_id;
			col_q       <= column_id;
			comp_q      <= component;
			value_q     <= value;
			coef_q      <= coefficient;
			last_row_q  <= last_in_row;
			last_item_q <= last_item;
		end
		unique case (state_q)
			S_ADDR: begin
				ra_q    <= row_lin[ADDR_W-1:0];
				ca_q    <= col_lin[ADDR_W-1:0];
				rok_q   <= rok;
				cok_q   <= cok;
				bad_q   <= bad;
				sat_q   <= 1'b0;
				rv_q    <= '0;
				csign_q <= coef_q[DATA_W-1];
				cmag_q  <= coef_q[DATA_W-1] ? DATA_W'(0) - coef_q : coef_q;
			end
			S_RD_ACC: begin
				osign_q <= rd_data_q[DATA_W-1];
				omag_q  <= rd_data_q[DATA_W-1] ? DATA_W'(0) - rd_data_q : rd_data_q;
				pacc_q  <= '0;
				if (func_q == F_READ) begin
					rv_q <= rd_data_q;
				end
			end
			S_MUL: begin
				pacc_q <= pacc_q + pp_sh;
				if (cnt_q == 2'd0) begin
					acc_q <= rd_data_q;
				end
			end
			S_RND: begin
				prod_q <= prod;
				sat_q  <= prod_sat;
				if (func_q == F_SCALE) begin
					rv_q <= prod;
				end
			end
			S_ADD: begin
				sat_q <= sat_q | sum_sat;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			read_value_q <= rv_q;
			status_q     <= bad_q ? ST_RANGE : (sat_q ? ST_SAT : ST_OK);
			pass_done_q  <= last_item_q;
		end
	end

	// vector store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign pass_done  = pass_done_q;

`ifndef SYNTHESIS
	a_accept_to_addr: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_ADDR)
		else $error("accepted request did not enter address stage");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_WR || state_q == S_ADD || state_q == S_CLR))
		else $error("store written outside a write state");

	a_write_valid_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> rok_q)
		else $error("store written at an out of range address");

	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && cnt_q == 2'd3 |=> state_q == S_RND)
		else $error("multiply sequence length wrong");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && state_q == S_IDLE)
		else $error("finished result not presented");

	a_gather_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |-> rok_q && cok_q)
		else $error("accumulate with an invalid address");
`endif

endmodule
`default_nettype wire
